FILE: rtl/bblr_pkg.sv
// ============================================================================
// bblr_pkg - shared types and constants of the RGB line box blur
// Field widths, register codes and the records carried between the
// window, divider and control parts of the block.
// ============================================================================
package bblr_pkg;

    localparam int CHAN_W     = 8;   // one color channel
    localparam int SUM_W      = 14;  // 63 * 255 fits
    localparam int RADIUS_W   = 5;
    localparam int DIV_W      = 6;   // 2*radius+1
    localparam int LEN_W      = 13;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;
    localparam int Q_BITS     = 8;   // quotient bits, one per divider cell

    localparam logic [CFG_IDX_W-1:0] REG_LINE_LENGTH = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_RADIUS      = CFG_IDX_W'(1);

    localparam logic [LEN_W-1:0]    LINE_LENGTH_RESET = LEN_W'(640);
    localparam logic [RADIUS_W-1:0] RADIUS_RESET      = RADIUS_W'(1);

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } pixel_t;

    typedef struct packed {
        logic [SUM_W-1:0] red;
        logic [SUM_W-1:0] green;
        logic [SUM_W-1:0] blue;
    } sum_t;

    // one entry of the divider pipeline
    typedef struct packed {
        logic   valid;
        logic   line_end;
        logic   run_last;
        sum_t   rem;
        pixel_t quo;
    } div_stage_t;

endpackage

FILE: rtl/bblr_pix_if.sv
// ============================================================================
// bblr_pix_if - input pixel channel
// Valid/ready channel carrying one RGB pixel per transaction.
// ============================================================================
interface bblr_pix_if;

    logic                       valid;
    logic                       ready;
    logic [bblr_pkg::CHAN_W-1:0] red_in;
    logic [bblr_pkg::CHAN_W-1:0] green_in;
    logic [bblr_pkg::CHAN_W-1:0] blue_in;

    modport source (output valid, output red_in, output green_in, output blue_in,
                    input ready);
    modport sink   (input valid, input red_in, input green_in, input blue_in,
                    output ready);

endinterface

FILE: rtl/bblr_res_if.sv
// ============================================================================
// bblr_res_if - blurred pixel channel
// Valid/ready channel carrying one blurred pixel and its markers.
// ============================================================================
interface bblr_res_if;

    logic                       valid;
    logic                       ready;
    logic [bblr_pkg::CHAN_W-1:0] red_out;
    logic [bblr_pkg::CHAN_W-1:0] green_out;
    logic [bblr_pkg::CHAN_W-1:0] blue_out;
    logic                       line_end;
    logic                       run_last;

    modport source (output valid, output red_out, output green_out, output blue_out,
                    output line_end, output run_last, input ready);
    modport sink   (input valid, input red_out, input green_out, input blue_out,
                    input line_end, input run_last, output ready);

endinterface

FILE: rtl/bblr_cfg_if.sv
// ============================================================================
// bblr_cfg_if - configuration write channel
// Valid/ready channel carrying a register index and write data.
// ============================================================================
interface bblr_cfg_if;

    logic                           valid;
    logic                           ready;
    logic [bblr_pkg::CFG_IDX_W-1:0]  index;
    logic [bblr_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);

endinterface

FILE: rtl/bblr_win_cell.sv
// ============================================================================
// bblr_win_cell - one cell of the pixel delay line
// Takes its neighbor's pixel on each shift, or the new pixel when it is
// the insertion point set by the window width.
// ============================================================================
module bblr_win_cell (
    input  logic             clk,
    input  logic             shift,
    input  logic             load,
    input  bblr_pkg::pixel_t new_px,
    input  bblr_pkg::pixel_t next_px,
    output bblr_pkg::pixel_t px
);

    bblr_pkg::pixel_t px_reg;

    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            px_reg <= load ? new_px : next_px;
        end
    end

    assign px = px_reg;

endmodule

FILE: rtl/bblr_div_cell.sv
// ============================================================================
// bblr_div_cell - one restoring division step for three channels
// Tries to subtract the pre-shifted divisor from each remainder and shifts
// the resulting quotient bit in from the right.
// ============================================================================
module bblr_div_cell (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        advance,
    input  logic [bblr_pkg::SUM_W:0]    divisor,
    input  bblr_pkg::div_stage_t        stage_in,
    output bblr_pkg::div_stage_t        stage_out
);

    bblr_pkg::div_stage_t stage_reg;
    bblr_pkg::div_stage_t stage_next;
    logic [bblr_pkg::SUM_W:0] tr_red;
    logic [bblr_pkg::SUM_W:0] tr_green;
    logic [bblr_pkg::SUM_W:0] tr_blue;

    assign tr_red   = {1'b0, stage_in.rem.red}   - divisor;
    assign tr_green = {1'b0, stage_in.rem.green} - divisor;
    assign tr_blue  = {1'b0, stage_in.rem.blue}  - divisor;

    always_comb
    begin
        stage_next = stage_in;
        stage_next.rem.red   = tr_red[bblr_pkg::SUM_W]
                             ? stage_in.rem.red : tr_red[bblr_pkg::SUM_W-1:0];
        stage_next.rem.green = tr_green[bblr_pkg::SUM_W]
                             ? stage_in.rem.green : tr_green[bblr_pkg::SUM_W-1:0];
        stage_next.rem.blue  = tr_blue[bblr_pkg::SUM_W]
                             ? stage_in.rem.blue : tr_blue[bblr_pkg::SUM_W-1:0];
        stage_next.quo.red   = {stage_in.quo.red[bblr_pkg::CHAN_W-2:0],
                                ~tr_red[bblr_pkg::SUM_W]};
        stage_next.quo.green = {stage_in.quo.green[bblr_pkg::CHAN_W-2:0],
                                ~tr_green[bblr_pkg::SUM_W]};
        stage_next.quo.blue  = {stage_in.quo.blue[bblr_pkg::CHAN_W-2:0],
                                ~tr_blue[bblr_pkg::SUM_W]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_reg <= '0;
        end
        else if (advance)
        begin
            stage_reg <= stage_next;
        end
    end

    assign stage_out = stage_reg;

endmodule

FILE: rtl/box_blur_line_rgb_core.sv
// ============================================================================
// box_blur_line_rgb_core - edge-clamped running-sum box blur of RGB lines
// Pixels of a line go in, one blurred pixel per window center comes out.
// ============================================================================
// Usage:
//   pixels  : valid/ready sink, one RGB pixel per transaction, line order.
//   results : valid/ready source, blurred pixel plus line_end (last center
//             of the line) and run_last (last result caused by the input).
//   cfg     : valid/ready write channel; index 0 = line_length, index 1 =
//             radius. A register write restarts the line. Write only while idle.
// Throughput: one pixel per cycle while results are taken. The last pixel
//   of a line flushes the remaining centers, with pixels.ready held low.
// Pipeline: the updated window sum of a transaction enters the divider
//   chain at the accepting edge, then passes through the 8-cell divider
//   chain, one register per quotient bit, before the result appears.
// Reset: line_length = 640, radius = 1, line position 0, pipeline empty.
// Stall: while a result waits on results.ready the sum stage and the whole
//   divider chain hold, and pixels.ready drops in the same cycle.
// ============================================================================
module box_blur_line_rgb_core #(
    parameter int MAX_RADIUS = 31,
    parameter int MAX_LINE   = 4096
) (
    input  logic          clk,
    input  logic          rst_n,
    bblr_cfg_if.sink      cfg,
    bblr_pix_if.sink      pixels,
    bblr_res_if.source    results
);

    // window depth covers the widest box the parameter allows
    localparam int WIN_CELLS = 2 * MAX_RADIUS + 1;
    localparam int POS_W     = $clog2(MAX_LINE);
    // wide enough for line_length, MAX_LINE and position + flush offset
    localparam int CMP_W     = (((POS_W + 1) > bblr_pkg::LEN_W)
                               ? (POS_W + 1) : bblr_pkg::LEN_W) + 1;
    localparam int RAD_CAP   = (MAX_RADIUS < 31) ? MAX_RADIUS : 31;
    localparam int STAGES    = bblr_pkg::Q_BITS;

    typedef enum logic {
        ST_RUN,
        ST_FLUSH
    } state_t;

    state_t                            state_reg,       state_next;
    logic [POS_W-1:0]                  pos_reg,         pos_next;
    logic [bblr_pkg::RADIUS_W-1:0]     step_reg,        step_next;
    bblr_pkg::sum_t                    sum_reg,         sum_next;
    bblr_pkg::pixel_t                  edge_reg,        edge_next;
    bblr_pkg::pixel_t                  hold_reg,        hold_next;
    bblr_pkg::div_stage_t              entry_reg,       entry_next;
    logic [bblr_pkg::LEN_W-1:0]        line_length_reg, line_length_next;
    logic [bblr_pkg::RADIUS_W-1:0]     radius_reg,      radius_next;

    logic [bblr_pkg::RADIUS_W-1:0]     radius_eff;
    logic [bblr_pkg::DIV_W-1:0]        divisor;
    logic [CMP_W-1:0]                  len_raw;
    logic [CMP_W-1:0]                  len_eff;
    logic [CMP_W-1:0]                  pos_x;
    logic [CMP_W-1:0]                  ahead;
    logic                              advance;
    logic                              take_px;
    logic                              flush_go;
    logic                              shift;
    logic                              first;
    logic                              last;
    logic                              cfg_wr;
    bblr_pkg::pixel_t                  x_px;
    bblr_pkg::pixel_t                  add_px;
    bblr_pkg::pixel_t                  drop_px;

    bblr_pkg::pixel_t                  cell_px [WIN_CELLS];
    logic [WIN_CELLS-1:0]              load;

    bblr_pkg::div_stage_t              div_stage [STAGES+1];
    logic [bblr_pkg::SUM_W:0]          div_shifted [STAGES];

    // ------------------------------------------------------------------
    // Effective settings (clamped as the register ranges require)
    // ------------------------------------------------------------------
    assign radius_eff = (radius_reg > bblr_pkg::RADIUS_W'(RAD_CAP))
                      ? bblr_pkg::RADIUS_W'(RAD_CAP) : radius_reg;
    assign divisor    = {radius_eff, 1'b1};

    assign len_raw = CMP_W'(line_length_reg);
    always_comb
    begin
        if (len_raw == '0)
        begin
            len_eff = CMP_W'(1);
        end
        else if (len_raw > CMP_W'(MAX_LINE))
        begin
            len_eff = CMP_W'(MAX_LINE);
        end
        else
        begin
            len_eff = len_raw;
        end
    end

    // ------------------------------------------------------------------
    // Handshakes: the whole pipeline moves when the output slot is free
    // ------------------------------------------------------------------
    assign advance      = !div_stage[STAGES].valid || results.ready;
    assign pixels.ready = advance && (state_reg == ST_RUN);
    assign cfg.ready    = 1'b1;
    assign cfg_wr       = cfg.valid && cfg.ready;
    assign take_px      = pixels.valid && pixels.ready;
    assign flush_go     = advance && (state_reg == ST_FLUSH);
    assign shift        = take_px || flush_go;

    assign x_px   = '{red: pixels.red_in, green: pixels.green_in, blue: pixels.blue_in};
    // during the flush the last pixel keeps entering the window (right edge clamp)
    assign add_px = (state_reg == ST_FLUSH) ? hold_reg : x_px;

    // position of the pixel entering the window this cycle
    assign pos_x = CMP_W'(pos_reg);
    assign ahead = pos_x + ((state_reg == ST_FLUSH) ? CMP_W'(step_reg) : '0);

    // pixel leaving the window: from the delay line once a full window of
    // this line has gone in, else the left edge clamp
    assign drop_px = (ahead >= CMP_W'(divisor)) ? cell_px[0] : edge_reg;

    assign first = (state_reg == ST_RUN) && (pos_reg == '0);
    assign last  = (pos_x + CMP_W'(1)) >= len_eff;

    // ------------------------------------------------------------------
    // Next-state logic
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next       = state_reg;
        pos_next         = pos_reg;
        step_next        = step_reg;
        sum_next         = sum_reg;
        edge_next        = edge_reg;
        hold_next        = hold_reg;
        entry_next       = entry_reg;
        line_length_next = line_length_reg;
        radius_next      = radius_reg;

        // window sums
        if (shift)
        begin
            if (first)
            begin
                edge_next     = x_px;
                sum_next.red   = bblr_pkg::SUM_W'(divisor) * bblr_pkg::SUM_W'(x_px.red);
                sum_next.green = bblr_pkg::SUM_W'(divisor) * bblr_pkg::SUM_W'(x_px.green);
                sum_next.blue  = bblr_pkg::SUM_W'(divisor) * bblr_pkg::SUM_W'(x_px.blue);
            end
            else
            begin
                sum_next.red   = sum_reg.red + bblr_pkg::SUM_W'(add_px.red)
                               - bblr_pkg::SUM_W'(drop_px.red);
                sum_next.green = sum_reg.green + bblr_pkg::SUM_W'(add_px.green)
                               - bblr_pkg::SUM_W'(drop_px.green);
                sum_next.blue  = sum_reg.blue + bblr_pkg::SUM_W'(add_px.blue)
                               - bblr_pkg::SUM_W'(drop_px.blue);
            end
        end

        // entry into the divider chain
        if (advance)
        begin
            entry_next.valid = 1'b0;
            entry_next.rem   = sum_next;
            entry_next.quo   = '0;
            if (take_px)
            begin
                entry_next.valid    = pos_x >= CMP_W'(radius_eff);
                entry_next.line_end = last && (radius_eff == '0);
                entry_next.run_last = !(last && (radius_eff != '0));
            end
            else if (flush_go)
            begin
                entry_next.valid    = ahead >= CMP_W'(radius_eff);
                entry_next.line_end = step_reg == radius_eff;
                entry_next.run_last = step_reg == radius_eff;
            end
        end

        // line sequencing
        if (take_px)
        begin
            if (last)
            begin
                if (radius_eff == '0)
                begin
                    pos_next = '0;
                end
                else
                begin
                    state_next = ST_FLUSH;
                    step_next  = bblr_pkg::RADIUS_W'(1);
                    hold_next  = x_px;
                end
            end
            else
            begin
                pos_next = pos_reg + POS_W'(1);
            end
        end
        else if (flush_go)
        begin
            if (step_reg == radius_eff)
            begin
                state_next = ST_RUN;
                pos_next   = '0;
            end
            else
            begin
                step_next = step_reg + bblr_pkg::RADIUS_W'(1);
            end
        end

        // register writes restart the line
        if (cfg_wr)
        begin
            unique case (cfg.index)
                bblr_pkg::REG_LINE_LENGTH:
                begin
                    line_length_next = cfg.data;
                    pos_next         = '0;
                    state_next       = ST_RUN;
                end
                bblr_pkg::REG_RADIUS:
                begin
                    radius_next = cfg.data[bblr_pkg::RADIUS_W-1:0];
                    pos_next    = '0;
                    state_next  = ST_RUN;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_RUN;
            pos_reg         <= '0;
            step_reg        <= '0;
            sum_reg         <= '0;
            edge_reg        <= '0;
            hold_reg        <= '0;
            entry_reg       <= '0;
            line_length_reg <= bblr_pkg::LINE_LENGTH_RESET;
            radius_reg      <= bblr_pkg::RADIUS_RESET;
        end
        else
        begin
            state_reg       <= state_next;
            pos_reg         <= pos_next;
            step_reg        <= step_next;
            sum_reg         <= sum_next;
            edge_reg        <= edge_next;
            hold_reg        <= hold_next;
            entry_reg       <= entry_next;
            line_length_reg <= line_length_next;
            radius_reg      <= radius_next;
        end
    end

    // ------------------------------------------------------------------
    // Pixel delay line: the new pixel enters at cell 2*radius, so cell 0
    // holds the pixel that went in 2*radius+1 shifts ago.
    // ------------------------------------------------------------------
    genvar gi;
    generate
        for (gi = 0; gi < WIN_CELLS; gi++)
        begin : g_win
            assign load[gi] = (int'(divisor) == (gi + 1));
            if (gi == WIN_CELLS - 1)
            begin : g_tail
                bblr_win_cell u_cell (
                    .clk     (clk),
                    .shift   (shift),
                    .load    (load[gi]),
                    .new_px  (add_px),
                    .next_px (add_px),
                    .px      (cell_px[gi])
                );
            end
            else
            begin : g_body
                bblr_win_cell u_cell (
                    .clk     (clk),
                    .shift   (shift),
                    .load    (load[gi]),
                    .new_px  (add_px),
                    .next_px (cell_px[gi + 1]),
                    .px      (cell_px[gi])
                );
            end
        end
    endgenerate

    // ------------------------------------------------------------------
    // Divider chain: cell k decides quotient bit STAGES-1-k
    // ------------------------------------------------------------------
    assign div_stage[0] = entry_reg;

    generate
        for (gi = 0; gi < STAGES; gi++)
        begin : g_div
            assign div_shifted[gi] = (bblr_pkg::SUM_W + 1)'(divisor) << (STAGES - 1 - gi);
            bblr_div_cell u_div (
                .clk       (clk),
                .rst_n     (rst_n),
                .advance   (advance),
                .divisor   (div_shifted[gi]),
                .stage_in  (div_stage[gi]),
                .stage_out (div_stage[gi + 1])
            );
        end
    endgenerate

    assign results.valid     = div_stage[STAGES].valid;
    assign results.red_out   = div_stage[STAGES].quo.red;
    assign results.green_out = div_stage[STAGES].quo.green;
    assign results.blue_out  = div_stage[STAGES].quo.blue;
    assign results.line_end  = div_stage[STAGES].line_end;
    assign results.run_last  = div_stage[STAGES].run_last;

endmodule

FILE: dv/box_blur_line_rgb_core_tb.sv
`timescale 1ns / 100ps
// ============================================================================
// box_blur_line_rgb_core_tb - self-checking bench for the RGB line box blur
// Drives pixel lines and register writes over valid/ready channels, predicts
// blurred pixels with an in-bench running-sum model or takes them from typed
// rows, and compares each result transaction field by field in arrival order.
// ============================================================================
module box_blur_line_rgb_core_tb;

    localparam int MAX_RADIUS  = 31;
    localparam int MAX_LINE    = 4096;
    localparam int WIN_DEPTH   = 2 * MAX_RADIUS + 2;   // pixel history kept by the predictor
    localparam int WIN_IDX_W   = $clog2(WIN_DEPTH);
    localparam int DRAIN_PAD   = 16;                   // outlasts the sum and divider pipeline
    localparam int CYCLE_LIMIT = 400000;

    // Index codes with no register behind them; writes there must be ignored.
    localparam logic [bblr_pkg::CFG_IDX_W-1:0] REG_SPARE_A = bblr_pkg::CFG_IDX_W'(2);
    localparam logic [bblr_pkg::CFG_IDX_W-1:0] REG_SPARE_B = bblr_pkg::CFG_IDX_W'(3);

    typedef enum logic {ROW_PIXEL, ROW_WRITE} row_kind_t;

    // Idle patterns: sink slow (rx idles 68%, tx 12%), source slow, none.
    typedef enum int {PACE_SINK_SLOW, PACE_SRC_SLOW, PACE_FULL} pace_t;

    typedef struct packed {
        bblr_pkg::pixel_t px;
        logic             line_end;
        logic             run_last;
    } blur_result_t;

    typedef struct {
        row_kind_t                       kind;
        logic [bblr_pkg::CFG_IDX_W-1:0]  idx;
        logic [bblr_pkg::CFG_DATA_W-1:0] data;
        bblr_pkg::pixel_t                px;
        bit                              typed;   // expected result given in the row
        blur_result_t                    want;
    } stim_row_t;

    logic clk;
    logic rst_n;

    bblr_cfg_if cfg_ch ();
    bblr_pix_if pix_ch ();
    bblr_res_if res_ch ();

    box_blur_line_rgb_core #(
        .MAX_RADIUS (MAX_RADIUS),
        .MAX_LINE   (MAX_LINE)
    ) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_ch),
        .pixels  (pix_ch),
        .results (res_ch)
    );

    // ------------------------------------------------------------------------
    // Clock and watchdog
    // ------------------------------------------------------------------------
    initial clk = 1'b0;

    always
    begin
        #5 clk = ~clk;
    end

    int unsigned cycle_count = 0;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Blur predictor state: its own copy of the registers and the line state
    // ------------------------------------------------------------------------
    logic [bblr_pkg::LEN_W-1:0]    pred_length;
    logic [bblr_pkg::RADIUS_W-1:0] pred_radius;
    bblr_pkg::pixel_t              line_buf [WIN_DEPTH];
    bblr_pkg::pixel_t              line_head;   // first pixel of the line, left edge clamp
    int                            sum_red;
    int                            sum_green;
    int                            sum_blue;
    int                            line_pos;    // index of the next pixel within the line

    blur_result_t blurred_q [$];         // blurred pixels still owed by the DUT
    blur_result_t step_results [$];      // results of the pixel just accepted

    int src_idle_pct;
    int sink_idle_pct;
    int error_count = 0;

    function automatic void slide_window(bblr_pkg::pixel_t add, bblr_pkg::pixel_t drop);
        sum_red   = sum_red   + int'(add.red)   - int'(drop.red);
        sum_green = sum_green + int'(add.green) - int'(drop.green);
        sum_blue  = sum_blue  + int'(add.blue)  - int'(drop.blue);
    endfunction

    function automatic blur_result_t blur_out(int d, bit at_end);
        blur_result_t o;
        o.px.red   = 8'(sum_red / d);
        o.px.green = 8'(sum_green / d);
        o.px.blue  = 8'(sum_blue / d);
        o.line_end = at_end;
        o.run_last = 1'b0;
        return o;
    endfunction

    // One accepted pixel: update window sums, append the blurred pixels it
    // releases to step_results. The last pixel of a line also flushes the
    // centers whose right half hangs past the line end (clamped to x).
    function automatic void blur_step(bblr_pkg::pixel_t x);
        int               len;
        int               r;
        int               d;
        int               p;
        int               j;
        int               first_idx;
        bit               last;
        bblr_pkg::pixel_t drop;
        first_idx = step_results.size();
        len = int'(pred_length);
        if (len == 0)
            len = 1;
        if (len > MAX_LINE)
            len = MAX_LINE;
        r = int'(pred_radius);
        if (r > MAX_RADIUS)
            r = MAX_RADIUS;
        d = 2 * r + 1;
        p = line_pos;
        line_buf[WIN_IDX_W'(p % WIN_DEPTH)] = x;
        if (p == 0)
        begin
            // window ending at the first pixel: x plus 2r left-edge copies of x
            line_head = x;
            sum_red   = d * int'(x.red);
            sum_green = d * int'(x.green);
            sum_blue  = d * int'(x.blue);
        end
        else
        begin
            drop = (p >= d) ? line_buf[WIN_IDX_W'((p - d) % WIN_DEPTH)] : line_head;
            slide_window(x, drop);
        end
        last = (p + 1 >= len);
        if (p >= r)
            step_results.push_back(blur_out(d, last && r == 0));
        if (last)
        begin
            for (j = 1; j <= r; j++)
            begin
                drop = (p + j >= d) ? line_buf[WIN_IDX_W'((p + j - d) % WIN_DEPTH)]
                                    : line_head;
                slide_window(x, drop);
                // short line: centers before 0 are never emitted
                if (p + j >= r)
                    step_results.push_back(blur_out(d, j == r));
            end
            line_pos = 0;
        end
        else
            line_pos = p + 1;
        if (step_results.size() > first_idx)
            step_results[step_results.size() - 1].run_last = 1'b1;
    endfunction

    // ------------------------------------------------------------------------
    // Result side: random backpressure, compare against the oldest expectation
    // ------------------------------------------------------------------------
    function automatic void check_field(string name, int want, int got);
        if (want != got)
        begin
            error_count++;
            $display("%0t: %s mismatch, expected %0h, actual %0h",
                     $time, name, want, got);
        end
    endfunction

    function automatic void check_result();
        blur_result_t want;
        if (blurred_q.size() == 0)
        begin
            error_count++;
            $display("%0t: unexpected result, expected none, actual %02h%02h%02h le=%0b rl=%0b",
                     $time, res_ch.red_out, res_ch.green_out, res_ch.blue_out,
                     res_ch.line_end, res_ch.run_last);
        end
        else
        begin
            want = blurred_q.pop_front();
            check_field("red_out",   int'(want.px.red),   int'(res_ch.red_out));
            check_field("green_out", int'(want.px.green), int'(res_ch.green_out));
            check_field("blue_out",  int'(want.px.blue),  int'(res_ch.blue_out));
            check_field("line_end",  int'(want.line_end), int'(res_ch.line_end));
            check_field("run_last",  int'(want.run_last), int'(res_ch.run_last));
        end
    endfunction

    // ready changes on the falling edge only; a transaction is taken at the
    // rising edge when valid and ready were both high just before it
    initial
    begin
        res_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            res_ch.ready <= ($urandom_range(0, 99) >= sink_idle_pct);
            @(posedge clk);
            if (rst_n && res_ch.valid && res_ch.ready)
                check_result();
        end
    end

    // ------------------------------------------------------------------------
    // Pixel and register drivers (entered and left on a falling edge)
    // ------------------------------------------------------------------------
    function automatic void set_pace(pace_t pace);
        case (pace)
            PACE_SINK_SLOW:
            begin
                src_idle_pct  = 12;
                sink_idle_pct = 68;
            end
            PACE_SRC_SLOW:
            begin
                src_idle_pct  = 68;
                sink_idle_pct = 12;
            end
            default:
            begin
                src_idle_pct  = 0;
                sink_idle_pct = 0;
            end
        endcase
    endfunction

    // Stop sending and wait until every owed result has come, then let the
    // pipeline settle (a pixel that releases no result may still be inside).
    task automatic drain();
        pix_ch.valid <= 1'b0;
        while (blurred_q.size() != 0)
            @(negedge clk);
        repeat (DRAIN_PAD) @(negedge clk);
    endtask

    task automatic push_pixel(bblr_pkg::pixel_t px, bit typed, blur_result_t want);
        // valid is written once per falling edge, so back-to-back pixels keep it high
        while ($urandom_range(0, 99) < src_idle_pct)
        begin
            pix_ch.valid <= 1'b0;
            @(negedge clk);
        end
        pix_ch.valid    <= 1'b1;
        pix_ch.red_in   <= px.red;
        pix_ch.green_in <= px.green;
        pix_ch.blue_in  <= px.blue;
        @(posedge clk);
        while (!pix_ch.ready)
            @(posedge clk);
        step_results.delete();
        blur_step(px);
        if (typed)
            blurred_q.push_back(want);
        else
            foreach (step_results[i])
                blurred_q.push_back(step_results[i]);
        @(negedge clk);
    endtask

    // Registers are only written with the block idle; any write to a real
    // register restarts the line.
    task automatic write_reg(logic [bblr_pkg::CFG_IDX_W-1:0] idx,
                             logic [bblr_pkg::CFG_DATA_W-1:0] data);
        drain();
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        if (idx == bblr_pkg::REG_LINE_LENGTH)
        begin
            pred_length = data[bblr_pkg::LEN_W-1:0];
            line_pos    = 0;
        end
        else if (idx == bblr_pkg::REG_RADIUS)
        begin
            pred_radius = data[bblr_pkg::RADIUS_W-1:0];
            line_pos    = 0;
        end
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
        @(negedge clk);
    endtask

    function automatic logic [bblr_pkg::CHAN_W-1:0] rand_chan();
        case ($urandom_range(0, 7))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic bblr_pkg::pixel_t rand_pixel();
        bblr_pkg::pixel_t px;
        px.red   = rand_chan();
        px.green = rand_chan();
        px.blue  = rand_chan();
        return px;
    endfunction

    // One setting: write both registers, then npix pixels (whole lines plus
    // maybe a partial one that the next write cuts off). Once per setting of more
    // than one pixel the source holds off until the block has emptied.
    task automatic run_lines(int len, int rad, int npix);
        int                              pause_at;
        int                              i;
        logic [bblr_pkg::CFG_DATA_W-1:0] rad_word;
        blur_result_t                    none;
        none     = '0;
        rad_word = bblr_pkg::CFG_DATA_W'($urandom);   // upper bits are don't-care
        rad_word[bblr_pkg::RADIUS_W-1:0] = bblr_pkg::RADIUS_W'(rad);
        write_reg(bblr_pkg::REG_LINE_LENGTH, bblr_pkg::CFG_DATA_W'(len));
        write_reg(bblr_pkg::REG_RADIUS, rad_word);
        pause_at = (npix > 1) ? $urandom_range(1, npix - 1) : -1;
        for (i = 0; i < npix; i++)
        begin
            if (i == pause_at)
                drain();
            push_pixel(rand_pixel(), 1'b0, none);
        end
    endtask

    // ------------------------------------------------------------------------
    // Directed table helpers
    // ------------------------------------------------------------------------
    function automatic stim_row_t pixel_row(bblr_pkg::pixel_t px);
        stim_row_t row;
        row.kind  = ROW_PIXEL;
        row.idx   = '0;
        row.data  = '0;
        row.px    = px;
        row.typed = 1'b0;
        row.want  = '0;
        return row;
    endfunction

    function automatic stim_row_t typed_row(bblr_pkg::pixel_t px, bblr_pkg::pixel_t want_px,
                                            bit le, bit rl);
        stim_row_t row;
        row = pixel_row(px);
        row.typed         = 1'b1;
        row.want.px       = want_px;
        row.want.line_end = le;
        row.want.run_last = rl;
        return row;
    endfunction

    function automatic stim_row_t write_row(logic [bblr_pkg::CFG_IDX_W-1:0] idx,
                                            logic [bblr_pkg::CFG_DATA_W-1:0] data);
        stim_row_t row;
        row = pixel_row('0);
        row.kind = ROW_WRITE;
        row.idx  = idx;
        row.data = data;
        return row;
    endfunction

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        stim_row_t dir_rows [$];
        int        ph;
        int        len;
        int        rad;
        int        nlines;

        // every DUT input known from time zero
        rst_n           = 1'b0;
        pix_ch.valid    = 1'b0;
        pix_ch.red_in   = '0;
        pix_ch.green_in = '0;
        pix_ch.blue_in  = '0;
        cfg_ch.valid    = 1'b0;
        cfg_ch.index    = '0;
        cfg_ch.data     = '0;
        set_pace(PACE_SINK_SLOW);

        pred_length = bblr_pkg::LINE_LENGTH_RESET;
        pred_radius = bblr_pkg::RADIUS_RESET;
        line_head   = '0;
        sum_red     = 0;
        sum_green   = 0;
        sum_blue    = 0;
        line_pos    = 0;

        // Reset defaults (640 / radius 1): first pixel releases nothing.
        dir_rows.push_back(pixel_row(24'hFF0080));
        dir_rows.push_back(pixel_row(24'h01FE7F));
        // Radius 0, one-pixel lines: every pixel comes back unchanged and
        // closes its line.
        dir_rows.push_back(write_row(bblr_pkg::REG_LINE_LENGTH, 13'd1));
        dir_rows.push_back(write_row(bblr_pkg::REG_RADIUS, 13'd0));
        dir_rows.push_back(typed_row(24'h000000, 24'h000000, 1'b1, 1'b1));
        dir_rows.push_back(typed_row(24'hFFFFFF, 24'hFFFFFF, 1'b1, 1'b1));
        dir_rows.push_back(typed_row(24'h5AA53C, 24'h5AA53C, 1'b1, 1'b1));
        // Length 0 behaves as 1.
        dir_rows.push_back(write_row(bblr_pkg::REG_LINE_LENGTH, 13'd0));
        dir_rows.push_back(typed_row(24'h0180FE, 24'h0180FE, 1'b1, 1'b1));
        // Writes to unmapped indexes change nothing.
        dir_rows.push_back(write_row(REG_SPARE_A, 13'h1FFF));
        dir_rows.push_back(write_row(REG_SPARE_B, 13'h0AAA));
        dir_rows.push_back(typed_row(24'hAA550F, 24'hAA550F, 1'b1, 1'b1));
        // Max radius on a one-pixel line: the window is all the same pixel.
        dir_rows.push_back(write_row(bblr_pkg::REG_RADIUS, 13'd31));
        dir_rows.push_back(typed_row(24'hFF00FF, 24'hFF00FF, 1'b1, 1'b1));
        // Short line under max radius: all results come from the flush.
        dir_rows.push_back(write_row(bblr_pkg::REG_LINE_LENGTH, 13'd3));
        dir_rows.push_back(pixel_row(24'h102030));
        dir_rows.push_back(pixel_row(24'h8090A0));
        dir_rows.push_back(pixel_row(24'hF0E0D0));
        // An ordinary line with both edges clamped.
        dir_rows.push_back(write_row(bblr_pkg::REG_RADIUS, 13'd2));
        dir_rows.push_back(write_row(bblr_pkg::REG_LINE_LENGTH, 13'd5));
        dir_rows.push_back(pixel_row(24'hFFFFFF));
        dir_rows.push_back(pixel_row(24'h000000));
        dir_rows.push_back(pixel_row(24'hFF00FF));
        dir_rows.push_back(pixel_row(24'h00FF00));
        dir_rows.push_back(pixel_row(24'h7F807F));
        // Radius 1, length 4, then a partial line cut off by the next write.
        dir_rows.push_back(write_row(bblr_pkg::REG_RADIUS, 13'd1));
        dir_rows.push_back(write_row(bblr_pkg::REG_LINE_LENGTH, 13'd4));
        dir_rows.push_back(pixel_row(24'h010203));
        dir_rows.push_back(pixel_row(24'hFEFDFC));
        dir_rows.push_back(pixel_row(24'h404040));
        dir_rows.push_back(pixel_row(24'hC0C0C0));
        dir_rows.push_back(pixel_row(24'h33CC99));
        dir_rows.push_back(pixel_row(24'hEE1177));

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (dir_rows[k])
        begin
            if (dir_rows[k].kind == ROW_WRITE)
                write_reg(dir_rows[k].idx, dir_rows[k].data);
            else
                push_pixel(dir_rows[k].px, dir_rows[k].typed, dir_rows[k].want);
        end

        // Random settings, three per pacing pattern. Mostly small radii on
        // two short lines, sometimes a large radius on a line shorter than
        // the window.
        for (ph = 0; ph < 9; ph++)
        begin
            set_pace(pace_t'(ph / 3));
            if ($urandom_range(0, 3) == 0)
            begin
                rad    = $urandom_range(5, MAX_RADIUS);
                len    = $urandom_range(1, 8);
                nlines = 1;
            end
            else
            begin
                rad    = $urandom_range(0, 3);
                len    = $urandom_range(2 * rad + 1, 2 * rad + 3);
                nlines = 2;
            end
            run_lines(len, rad, len * nlines + int'($urandom_range(0, 1)));
        end

        // Extremes at full rate: a full window from the delay line at max
        // radius, the largest line length, and an oversized length that
        // must clamp to MAX_LINE (no line end inside the pixels sent).
        set_pace(PACE_FULL);
        run_lines(64, MAX_RADIUS, 64);
        run_lines(MAX_LINE, 0, 4);
        run_lines(8191, 0, 6);

        drain();

        if (error_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

FILE: files.f
rtl/bblr_pkg.sv
rtl/bblr_pix_if.sv
rtl/bblr_res_if.sv
rtl/bblr_cfg_if.sv
rtl/bblr_win_cell.sv
rtl/bblr_div_cell.sv
rtl/box_blur_line_rgb_core.sv
dv/box_blur_line_rgb_core_tb.sv
